FILE: rtl/core/euler_rotation_3d_assert.svh
// Assertion macros for the Euler rotation block.
// Each macro takes a label, a condition and the consequence that must follow.
`ifndef EULER_ROTATION_3D_ASSERT_SVH
`define EULER_ROTATION_3D_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define ER3D_ASSERT_SAME(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error("er3d: same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define ER3D_ASSERT_NEXT(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error("er3d: next-cycle check failed");

`endif

FILE: rtl/core/er3d_pkg.sv
`default_nettype none

package er3d_pkg;

	// Sine table geometry: the table covers one turn, only one quarter is stored.
	localparam int SINE_TABLE_BITS = 10;
	localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
	localparam int QUARTER         = 1 << QUARTER_BITS;
	localparam int MAG_W           = 15;

	// Fixed-point widths.
	localparam int COORD_W = 32;
	localparam int ANGLE_W = 16;
	localparam int TRIG_W  = 16;
	localparam int TERM_W  = 18;
	localparam int PROD_W  = TERM_W + COORD_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int FRAC    = 15;
	localparam int RND_W   = ACC_W - FRAC;

	// Series constants used to build the sine table at elaboration.
	localparam logic [63:0] HALF_PI_Q60  = 64'h1921FB54442D1846;
	localparam int          TAYLOR_TERMS = 13;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic        [ANGLE_W-1:0] angle_t;
	typedef logic signed [TRIG_W-1:0]  trig_t;
	typedef logic signed [TERM_W-1:0]  term_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	localparam acc_t ACC_HALF = acc_t'(1) <<< (FRAC - 1);

	// Input word: a point and its three rotation angles.
	typedef struct packed {
		coord_t in_x;
		coord_t in_y;
		coord_t in_z;
		angle_t angle_x;
		angle_t angle_y;
		angle_t angle_z;
	} er3d_point_t;

	// Output word: the rotated point.
	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
	} er3d_result_t;

	// Upper part of a 64 by 64 product, shifted down by 60 bits.
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// Unsigned quotient by shift and subtract, elaboration only.
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Quarter-wave sine magnitude by a fixed-point series, elaboration only.
	function automatic logic [MAG_W-1:0] quarter_sine(input int j);
		logic [63:0] mask;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] divisor;
		logic [63:0] s40;
		logic [63:0] v;
		mask = (64'd1 << QUARTER_BITS) - 64'd1;
		x = (HALF_PI_Q60 >> QUARTER_BITS) * 64'(j)
			+ (((HALF_PI_Q60 & mask) * 64'(j)) >> QUARTER_BITS);
		x2 = mul_q60(x, x);
		term = x;
		sum = x;
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			divisor = 64'((2 * n) * (2 * n + 1));
			term = div_u64(mul_q60(term, x2), divisor);
			if ((n & 1) == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		s40 = (sum + (64'd1 << 19)) >> 20;
		v = (64'd32767 * s40 + (64'd1 << 39)) >> 40;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[MAG_W-1:0];
	endfunction

	// Quarter table including the entry at a full quarter turn.
	function automatic logic [(QUARTER+1)*MAG_W-1:0] build_quarter_rom();
		logic [(QUARTER+1)*MAG_W-1:0] rom;
		rom = '0;
		for (int j = 0; j <= QUARTER; j++) begin
			rom[j*MAG_W +: MAG_W] = quarter_sine(j);
		end
		return rom;
	endfunction

	localparam logic [(QUARTER+1)*MAG_W-1:0] QSINE_ROM = build_quarter_rom();

endpackage

`default_nettype wire

FILE: rtl/core/euler_rotation_3d.sv
// Euler rotation R = Rz * Ry * Rx of a Q16.16 point, fully pipelined.
// Six register stages, s1 to s6; a result is valid once its point reaches s6.
// Throughput: one point per cycle while result_stall is low; a stall only
// fills the bubbles ahead of it.
// Reset clears the valid bit of every stage; the data registers are not reset.
`default_nettype none

`include "euler_rotation_3d_assert.svh"

module euler_rotation_3d (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   point_valid,
	output      logic                   point_stall,
	input  wire er3d_pkg::er3d_point_t  point,
	output      logic                   result_valid,
	input  wire logic                   result_stall,
	output      er3d_pkg::er3d_result_t result
);

	localparam int TB = er3d_pkg::SINE_TABLE_BITS;
	localparam int QB = er3d_pkg::QUARTER_BITS;

	// Signed sine of a table index, from the quarter table by symmetry.
	function automatic er3d_pkg::trig_t rom_sine(input logic [TB-1:0] k);
		logic [1:0]                      q;
		logic [QB:0]                     j;
		logic [er3d_pkg::MAG_W-1:0]      mag;
		er3d_pkg::trig_t                 m;
		q = k[TB-1 -: 2];
		j = {1'b0, k[QB-1:0]};
		if (q[0]) begin
			j = (QB+1)'(er3d_pkg::QUARTER) - j;
		end
		mag = er3d_pkg::QSINE_ROM[j*er3d_pkg::MAG_W +: er3d_pkg::MAG_W];
		m = signed'({1'b0, mag});
		return q[1] ? -m : m;
	endfunction

	// Cosine is the sine a quarter turn further on, wrapping round the table.
	function automatic er3d_pkg::trig_t rom_cosine(input logic [TB-1:0] k);
		return rom_sine(k + TB'(er3d_pkg::QUARTER));
	endfunction

	// Q1.15 product rounded half up back to Q1.15.
	function automatic er3d_pkg::trig_t qmul(input er3d_pkg::trig_t a, input er3d_pkg::trig_t b);
		logic signed [2*er3d_pkg::TRIG_W-1:0] p;
		p = a * b + (2*er3d_pkg::TRIG_W)'(32'sd1 <<< (er3d_pkg::FRAC - 1));
		return p[er3d_pkg::FRAC +: er3d_pkg::TRIG_W];
	endfunction

	// Drop the fraction bits of a rounded sum and clamp to 32 bits.
	function automatic er3d_pkg::coord_t round_sat(input er3d_pkg::acc_t a);
		logic signed [er3d_pkg::RND_W-1:0] r;
		r = signed'(a[er3d_pkg::ACC_W-1:er3d_pkg::FRAC]);
		if (r[er3d_pkg::RND_W-1:er3d_pkg::COORD_W-1]
			== {(er3d_pkg::RND_W-er3d_pkg::COORD_W+1){r[er3d_pkg::COORD_W-1]}}) begin
			return r[er3d_pkg::COORD_W-1:0];
		end else if (r[er3d_pkg::RND_W-1]) begin
			return {1'b1, {(er3d_pkg::COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(er3d_pkg::COORD_W-1){1'b1}}};
		end
	endfunction

	// Pipeline state.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	er3d_pkg::trig_t  sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	er3d_pkg::coord_t x_s1, y_s1, z_s1;

	er3d_pkg::trig_t  czsy_s2, szsy_s2, m00_s2, m10_s2, m20_s2, m21_s2, m22_s2;
	er3d_pkg::trig_t  szcx_s2, szsx_s2, czcx_s2, czsx_s2, sx_s2, cx_s2;
	er3d_pkg::coord_t x_s2, y_s2, z_s2;

	er3d_pkg::term_t  mat_s3 [9];
	er3d_pkg::coord_t x_s3, y_s3, z_s3;

	er3d_pkg::prod_t  prod_s4 [9];
	er3d_pkg::acc_t   acc_s5 [3];
	er3d_pkg::coord_t res_s6 [3];

	// A stage advances when it is empty or the stage after it advances.
	always_comb begin
		en_s6 = !valid_s6 || !result_stall;
		en_s5 = !valid_s5 || en_s6;
		en_s4 = !valid_s4 || en_s5;
		en_s3 = !valid_s3 || en_s4;
		en_s2 = !valid_s2 || en_s3;
		en_s1 = !valid_s1 || en_s2;
	end

	assign point_stall  = !en_s1;
	assign result_valid = valid_s6;
	assign result.out_x = res_s6[0];
	assign result.out_y = res_s6[1];
	assign result.out_z = res_s6[2];

	// Valid bits travel with their words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= point_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
		end
	end

	// Stage 1: sine and cosine of each angle from the table.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			sx_s1 <= rom_sine(point.angle_x[er3d_pkg::ANGLE_W-1 -: TB]);
			cx_s1 <= rom_cosine(point.angle_x[er3d_pkg::ANGLE_W-1 -: TB]);
			sy_s1 <= rom_sine(point.angle_y[er3d_pkg::ANGLE_W-1 -: TB]);
			cy_s1 <= rom_cosine(point.angle_y[er3d_pkg::ANGLE_W-1 -: TB]);
			sz_s1 <= rom_sine(point.angle_z[er3d_pkg::ANGLE_W-1 -: TB]);
			cz_s1 <= rom_cosine(point.angle_z[er3d_pkg::ANGLE_W-1 -: TB]);
			x_s1  <= point.in_x;
			y_s1  <= point.in_y;
			z_s1  <= point.in_z;
		end
	end

	// Stage 2: first level of rounded trigonometric products.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			czsy_s2 <= qmul(cz_s1, sy_s1);
			szsy_s2 <= qmul(sz_s1, sy_s1);
			m00_s2  <= qmul(cz_s1, cy_s1);
			m10_s2  <= qmul(sz_s1, cy_s1);
			m20_s2  <= -sy_s1;
			m21_s2  <= qmul(cy_s1, sx_s1);
			m22_s2  <= qmul(cy_s1, cx_s1);
			szcx_s2 <= qmul(sz_s1, cx_s1);
			szsx_s2 <= qmul(sz_s1, sx_s1);
			czcx_s2 <= qmul(cz_s1, cx_s1);
			czsx_s2 <= qmul(cz_s1, sx_s1);
			sx_s2   <= sx_s1;
			cx_s2   <= cx_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
		end
	end

	// Stage 3: second-level products and the sums that finish the matrix.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			mat_s3[0] <= er3d_pkg::TERM_W'(m00_s2);
			mat_s3[1] <= er3d_pkg::TERM_W'(qmul(czsy_s2, sx_s2))
				- er3d_pkg::TERM_W'(szcx_s2);
			mat_s3[2] <= er3d_pkg::TERM_W'(qmul(czsy_s2, cx_s2))
				+ er3d_pkg::TERM_W'(szsx_s2);
			mat_s3[3] <= er3d_pkg::TERM_W'(m10_s2);
			mat_s3[4] <= er3d_pkg::TERM_W'(qmul(szsy_s2, sx_s2))
				+ er3d_pkg::TERM_W'(czcx_s2);
			mat_s3[5] <= er3d_pkg::TERM_W'(qmul(szsy_s2, cx_s2))
				- er3d_pkg::TERM_W'(czsx_s2);
			mat_s3[6] <= er3d_pkg::TERM_W'(m20_s2);
			mat_s3[7] <= er3d_pkg::TERM_W'(m21_s2);
			mat_s3[8] <= er3d_pkg::TERM_W'(m22_s2);
			x_s3      <= x_s2;
			y_s3      <= y_s2;
			z_s3      <= z_s2;
		end
	end

	// Stage 4: one term by coordinate product per matrix entry.
	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int r = 0; r < 3; r++) begin
				prod_s4[3*r]     <= mat_s3[3*r] * x_s3;
				prod_s4[3*r + 1] <= mat_s3[3*r + 1] * y_s3;
				prod_s4[3*r + 2] <= mat_s3[3*r + 2] * z_s3;
			end
		end
	end

	// Stage 5: row sums with the rounding half already added.
	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int r = 0; r < 3; r++) begin
				acc_s5[r] <= er3d_pkg::ACC_W'(prod_s4[3*r])
					+ er3d_pkg::ACC_W'(prod_s4[3*r + 1])
					+ er3d_pkg::ACC_W'(prod_s4[3*r + 2])
					+ er3d_pkg::ACC_HALF;
			end
		end
	end

	// Stage 6: output register after rounding and saturation.
	always_ff @(posedge clk) begin
		if (en_s6) begin
			for (int r = 0; r < 3; r++) begin
				res_s6[r] <= round_sat(acc_s5[r]);
			end
		end
	end

	// An empty output register means nothing can hold the pipeline up.
	`ER3D_ASSERT_SAME(a_no_stall_when_empty, !result_valid, !point_stall)
	// A finished row sum moves into an output register that is not held.
	`ER3D_ASSERT_NEXT(a_drain_to_output, valid_s5 && !result_stall, result_valid)
	// A non-negative row sum can never come out negative after saturation.
	`ER3D_ASSERT_NEXT(a_sat_sign_x, valid_s5 && en_s6 && !acc_s5[0][er3d_pkg::ACC_W-1],
		!result.out_x[er3d_pkg::COORD_W-1])

endmodule

`default_nettype wire

FILE: tb/sv/euler_rotation_3d_test.sv
`timescale 1ns / 1ps

module euler_rotation_3d_test;

	localparam int TBITS        = er3d_pkg::SINE_TABLE_BITS;
	localparam int TABLE_SIZE   = 1 << TBITS;
	localparam int SERIES_TERMS = 13;
	localparam int RANDOM_ITEMS = 1700;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	localparam er3d_pkg::coord_t COORD_MAX = 32'sh7FFF_FFFF;
	localparam er3d_pkg::coord_t COORD_MIN = 32'sh8000_0000;
	localparam er3d_pkg::coord_t COORD_ONE = 32'sh0001_0000;

	localparam er3d_pkg::angle_t TURN_EIGHTH  = 16'h2000;
	localparam er3d_pkg::angle_t TURN_QUARTER = 16'h4000;
	localparam er3d_pkg::angle_t TURN_HALF    = 16'h8000;
	localparam er3d_pkg::angle_t TURN_3Q      = 16'hC000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   point_valid = 1'b0;
	logic                   point_stall;
	er3d_pkg::er3d_point_t  point = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	er3d_pkg::er3d_result_t result;

	er3d_pkg::er3d_point_t  pending_points[$];
	er3d_pkg::er3d_result_t rotated_points[$];
	er3d_pkg::er3d_result_t expected_word;

	int unsigned sent_count = 0;
	int unsigned received_count = 0;
	int unsigned send_wait = 0;
	int unsigned recv_wait = 0;
	int unsigned hold_left = 0;
	bit          failed = 1'b0;

	euler_rotation_3d dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point        (point),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	// Bits 123 down to 60 of the full unsigned product.
	function automatic logic [63:0] q60_high(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] wide;
		wide = {64'd0, a} * {64'd0, b};
		return wide[123:60];
	endfunction

	// Sine table entry k, folded onto the quarter wave and summed as a series.
	function automatic int table_sine(input int unsigned k);
		int unsigned quadrant;
		int unsigned j;
		logic [63:0] mask;
		logic [63:0] arg;
		logic [63:0] sq;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] s40;
		logic [63:0] mag;
		k = k & (TABLE_SIZE - 1);
		quadrant = k >> er3d_pkg::QUARTER_BITS;
		j = k & (er3d_pkg::QUARTER - 1);
		if ((quadrant & 1) != 0) begin
			j = er3d_pkg::QUARTER - j;
		end
		mask = (64'd1 << er3d_pkg::QUARTER_BITS) - 64'd1;
		arg = (er3d_pkg::HALF_PI_Q60 >> er3d_pkg::QUARTER_BITS) * 64'(j)
			+ (((er3d_pkg::HALF_PI_Q60 & mask) * 64'(j)) >> er3d_pkg::QUARTER_BITS);
		sq = q60_high(arg, arg);
		term = arg;
		acc = arg;
		for (int n = 1; n <= SERIES_TERMS; n++) begin
			term = q60_high(term, sq) / 64'((2 * n) * (2 * n + 1));
			if ((n & 1) != 0) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		s40 = (acc + (64'd1 << 19)) >> 20;
		mag = (64'd32767 * s40 + (64'd1 << 39)) >> 40;
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		return ((quadrant & 2) != 0) ? -int'(mag) : int'(mag);
	endfunction

	// Q1.15 product, rounded half up back to Q1.15.
	function automatic int qmul(input int a, input int b);
		longint prod;
		prod = longint'(a) * longint'(b);
		return int'((prod + 64'sd16384) >>> 15);
	endfunction

	// One row of the matrix against the point, rounded and clamped to Q16.16.
	function automatic er3d_pkg::coord_t project_row(input int a, input int b, input int c,
			input er3d_pkg::coord_t x, input er3d_pkg::coord_t y,
			input er3d_pkg::coord_t z);
		longint acc;
		acc = longint'(a) * longint'(x) + longint'(b) * longint'(y)
			+ longint'(c) * longint'(z);
		acc = (acc + 64'sd16384) >>> 15;
		if (acc > longint'(COORD_MAX)) begin
			acc = longint'(COORD_MAX);
		end
		if (acc < longint'(COORD_MIN)) begin
			acc = longint'(COORD_MIN);
		end
		return er3d_pkg::coord_t'(acc);
	endfunction

	// Rotated point for one input word, matrix built as Rz * Ry * Rx.
	function automatic er3d_pkg::er3d_result_t rotate_point(input er3d_pkg::er3d_point_t p);
		int unsigned ix, iy, iz;
		int sx, cx, sy, cy, sz, cz;
		int czsy, szsy;
		int m00, m01, m02, m10, m11, m12, m20, m21, m22;
		er3d_pkg::er3d_result_t r;
		ix = int'(p.angle_x) >> (er3d_pkg::ANGLE_W - TBITS);
		iy = int'(p.angle_y) >> (er3d_pkg::ANGLE_W - TBITS);
		iz = int'(p.angle_z) >> (er3d_pkg::ANGLE_W - TBITS);
		sx = table_sine(ix);
		cx = table_sine(ix + er3d_pkg::QUARTER);
		sy = table_sine(iy);
		cy = table_sine(iy + er3d_pkg::QUARTER);
		sz = table_sine(iz);
		cz = table_sine(iz + er3d_pkg::QUARTER);
		czsy = qmul(cz, sy);
		szsy = qmul(sz, sy);
		m00 = qmul(cz, cy);
		m01 = qmul(czsy, sx) - qmul(sz, cx);
		m02 = qmul(czsy, cx) + qmul(sz, sx);
		m10 = qmul(sz, cy);
		m11 = qmul(szsy, sx) + qmul(cz, cx);
		m12 = qmul(szsy, cx) - qmul(cz, sx);
		m20 = -sy;
		m21 = qmul(cy, sx);
		m22 = qmul(cy, cx);
		r.out_x = project_row(m00, m01, m02, p.in_x, p.in_y, p.in_z);
		r.out_y = project_row(m10, m11, m12, p.in_x, p.in_y, p.in_z);
		r.out_z = project_row(m20, m21, m22, p.in_x, p.in_y, p.in_z);
		return r;
	endfunction

	// Idle cycles per word; every fourth block of a hundred words runs flat out.
	function automatic int unsigned draw_wait(input int unsigned index);
		if (((index / 100) % 4) == 0) begin
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	function automatic er3d_pkg::coord_t rand_coord();
		case ($urandom_range(0, 4))
			0: begin
				return er3d_pkg::coord_t'(int'($urandom_range(0, 32'h0040_0000))
					- 32'sh0020_0000);
			end
			1: begin
				case ($urandom_range(0, 4))
					0: return COORD_MAX;
					1: return COORD_MIN;
					2: return '0;
					3: return 32'sd1;
					default: return -32'sd1;
				endcase
			end
			default: begin
				return er3d_pkg::coord_t'($urandom);
			end
		endcase
	endfunction

	function automatic er3d_pkg::angle_t rand_angle();
		if ($urandom_range(0, 3) == 0) begin
			return er3d_pkg::angle_t'(($urandom_range(0, 3) << 14) | $urandom_range(0, 63));
		end
		return er3d_pkg::angle_t'($urandom_range(0, 65535));
	endfunction

	task automatic add_point(input er3d_pkg::coord_t x, input er3d_pkg::coord_t y,
			input er3d_pkg::coord_t z, input er3d_pkg::angle_t ax,
			input er3d_pkg::angle_t ay, input er3d_pkg::angle_t az);
		er3d_pkg::er3d_point_t p;
		p.in_x = x;
		p.in_y = y;
		p.in_z = z;
		p.angle_x = ax;
		p.angle_y = ay;
		p.angle_z = az;
		pending_points.push_back(p);
	endtask

	task automatic check_field(input string name, input er3d_pkg::coord_t want,
			input er3d_pkg::coord_t got);
		if (want !== got) begin
			$error("%s expected %0d got %0d", name, want, got);
			failed = 1'b1;
		end
	endtask

	// Sender: offers the next pending word once its idle count has run out.
	always @(posedge clk) begin
		if (arst_n) begin
			if (point_valid && !point_stall) begin
				rotated_points.push_back(rotate_point(point));
				sent_count++;
			end
			if (!point_valid || !point_stall) begin
				if (send_wait > 0) begin
					send_wait--;
					point_valid <= 1'b0;
				end else if (pending_points.size() > 0) begin
					point <= pending_points.pop_front();
					point_valid <= 1'b1;
					send_wait = draw_wait(sent_count);
				end else begin
					point_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each word taken and stalls at random, with two long hold-offs.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (rotated_points.size() == 0) begin
					$error("result word arrived with no point outstanding");
					failed = 1'b1;
				end else begin
					expected_word = rotated_points.pop_front();
					check_field("out_x", expected_word.out_x, result.out_x);
					check_field("out_y", expected_word.out_y, result.out_y);
					check_field("out_z", expected_word.out_z, result.out_z);
				end
				received_count++;
				recv_wait = draw_wait(received_count + 200);
				if (received_count == 300 || received_count == 1100) begin
					hold_left = HOLD_CYCLES;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		// Zero point, identity, the coordinate extremes and a half turn about each axis.
		add_point('0, '0, '0, '0, '0, '0);
		add_point(COORD_MAX, COORD_MAX, COORD_MAX, '0, '0, '0);
		add_point(COORD_MIN, COORD_MIN, COORD_MIN, '0, '0, '0);
		add_point(32'sd1, -32'sd1, 32'sd1, TURN_HALF, TURN_HALF, TURN_HALF);
		// Quarter turns about each axis in turn, then mixed turns about all three at once.
		add_point(COORD_ONE, COORD_ONE, COORD_ONE, TURN_QUARTER, '0, '0);
		add_point(COORD_ONE, COORD_ONE, COORD_ONE, '0, TURN_QUARTER, '0);
		add_point(COORD_ONE, COORD_ONE, COORD_ONE, '0, '0, TURN_QUARTER);
		add_point(COORD_ONE, -COORD_ONE, COORD_ONE, TURN_HALF, TURN_3Q, TURN_QUARTER);
		add_point(COORD_MAX, COORD_MIN, COORD_ONE, TURN_3Q, TURN_3Q, TURN_3Q);
		// Largest angles, and lower angle bits that the table index drops.
		add_point(COORD_ONE, COORD_ONE, COORD_ONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_point(COORD_ONE, COORD_ONE, COORD_ONE, 16'h003F, 16'h003F, 16'h003F);
		add_point(COORD_ONE, COORD_ONE, COORD_ONE, 16'hFFC0, 16'h0040, 16'h7FFF);
		add_point(COORD_MIN, COORD_MAX, COORD_MIN, 16'hAAAA, 16'h5555, 16'h1234);
		// Sums that leave the 32-bit range and must clamp at both ends.
		add_point(COORD_MAX, COORD_MIN, '0, '0, '0, TURN_EIGHTH);
		add_point(COORD_MIN, COORD_MAX, '0, '0, '0, TURN_EIGHTH);
		add_point(COORD_MAX, '0, COORD_MAX, '0, TURN_EIGHTH, '0);
		add_point(COORD_MIN, '0, COORD_MIN, '0, TURN_EIGHTH, '0);
		add_point('0, COORD_MAX, COORD_MIN, TURN_EIGHTH, '0, '0);
		add_point(COORD_MAX, COORD_MAX, COORD_MAX, TURN_EIGHTH, TURN_EIGHTH, TURN_EIGHTH);
		add_point(COORD_MIN, COORD_MIN, COORD_MIN, TURN_EIGHTH, TURN_EIGHTH, TURN_EIGHTH);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			add_point(rand_coord(), rand_coord(), rand_coord(),
				rand_angle(), rand_angle(), rand_angle());
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_points.size() != 0 || point_valid || rotated_points.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (!failed) begin
			$display("euler_rotation_3d verification clean");
		end else begin
			$display("euler_rotation_3d verification failed");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("euler_rotation_3d verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/er3d_pkg.sv
rtl/core/euler_rotation_3d.sv
tb/sv/euler_rotation_3d_test.sv
